// ===== rtl/core/vlmr_pkg.sv =====
// vlmr_pkg: shared types and fixed constants of the message ring core
// used by vlmr_stage and variable_length_message_ring_core
// no dependencies
package vlmr_pkg;

  // fixed message framing
  localparam int unsigned HEADER_BYTES    = 4;
  localparam int unsigned MAX_BATCH_BYTES = 256;

  // staging store geometry
  localparam int unsigned STAGE_WORDS = 64;
  localparam int unsigned STAGE_BYTES = STAGE_WORDS * 4;
  localparam int unsigned STAGE_IW    = $clog2(STAGE_WORDS);

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_FETCH  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_NO_ROOM     = 3'd1,
    ST_TOO_LONG    = 3'd2,
    ST_FETCH_EMPTY = 3'd3,
    ST_FETCH_WORD  = 3'd4
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] out_word;
    logic [8:0]  message_bytes;
    logic        out_last;
    logic        ring_empty;
  } out_item_t;

  // requests from the sequencer to the staging unit
  typedef struct packed {
    logic                push;
    logic                clear;
    logic [31:0]         data;
    logic [2:0]          count;
    logic                rd_en;
    logic [STAGE_IW-1:0] rd_idx;
  } stage_req_t;

  typedef struct packed {
    logic [8:0]  staged_bytes;
    logic [31:0] partial_word;
    logic [31:0] rd_data;
  } stage_rsp_t;

endpackage

// ===== rtl/core/vlmr_in_if.sv =====
// vlmr_in_if: valid/ready channel carrying one request item
// no dependencies
interface vlmr_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last;

  modport source (output valid, output opcode, output data_word, output byte_count,
                  output last, input ready);
  modport sink (input valid, input opcode, input data_word, input byte_count,
                input last, output ready);
endinterface

// ===== rtl/core/vlmr_out_if.sv =====
// vlmr_out_if: valid/ready channel carrying one result item
// no dependencies
interface vlmr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] out_word;
  logic [8:0]  message_bytes;
  logic        out_last;
  logic        ring_empty;

  modport source (output valid, output status, output out_word, output message_bytes,
                  output out_last, output ring_empty, input ready);
  modport sink (input valid, input status, input out_word, input message_bytes,
                input out_last, input ring_empty, output ready);
endinterface

// ===== rtl/core/vlmr_stage.sv =====
// vlmr_stage: byte packer and 64-word staging memory for the message being built
// depends on vlmr_pkg
module vlmr_stage import vlmr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  stage_req_t req_i,
  output stage_rsp_t rsp_o
);

  logic [8:0]  staged_q, staged_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] rd_q;
  logic [31:0] mem [STAGE_WORDS];

  logic [2:0]  cnt;
  logic [8:0]  room;
  logic [2:0]  eff;
  logic [1:0]  off;
  logic [31:0] data_m;
  logic [63:0] merged;
  logic [2:0]  total;
  logic        spill;

  always_comb begin
    cnt  = (req_i.count > 3'd4) ? 3'd4 : req_i.count;
    room = 9'(STAGE_BYTES) - staged_q;
    // bytes past a full staging store are dropped
    eff  = ({6'd0, cnt} > room) ? room[2:0] : cnt;
    off  = staged_q[1:0];
    for (int b = 0; b < 4; b++) begin
      data_m[b*8 +: 8] = (3'(b) < eff) ? req_i.data[b*8 +: 8] : 8'd0;
    end
    merged = {32'd0, acc_q} | ({32'd0, data_m} << {off, 3'b000});
    total  = {1'b0, off} + eff;
    spill  = total[2];
    staged_d = staged_q;
    acc_d    = acc_q;
    if (req_i.clear) begin
      staged_d = '0;
      acc_d    = '0;
    end else if (req_i.push) begin
      staged_d = staged_q + {6'd0, eff};
      acc_d    = spill ? merged[63:32] : merged[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      staged_q <= '0;
      acc_q    <= '0;
    end else begin
      staged_q <= staged_d;
      acc_q    <= acc_d;
    end
  end

  // completed words go to memory, the partial word stays in acc_q
  always_ff @(posedge clk_i) begin
    if (req_i.push && !req_i.clear && spill) begin
      mem[staged_q[STAGE_IW+1:2]] <= merged[31:0];
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_idx];
    end
  end

  assign rsp_o.staged_bytes = staged_q;
  assign rsp_o.partial_word = acc_q;
  assign rsp_o.rd_data      = rd_q;

endmodule

// ===== rtl/core/variable_length_message_ring_core.sv =====
// variable_length_message_ring_core: ring of 32-bit words holding framed messages
// depends on vlmr_pkg, vlmr_in_if, vlmr_out_if and vlmr_stage
//
// channel | dir | handshake         | payload
// in_i    | in  | valid/ready       | opcode, data_word, byte_count, last
// out_o   | out | valid/ready       | status, out_word, message_bytes, out_last, ring_empty
//
// an append that is not last gives one result
// a last append does the room check and header write in S_CHECK, then copies each
// payload word in S_COPY, one per cycle, bound by the single ring write port
// a fetch reads the header in S_FHDR, then sends one word per cycle through the ring
// read port while the output queue has room, each word cleared as it leaves
// reset clears pointers and control only; the ring needs no clearing pass since
// every word that is read was written by a commit first
// results wait in a two-entry output queue; a full queue stalls the sequencer
module variable_length_message_ring_core import vlmr_pkg::*; #(
  parameter int unsigned RING_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vlmr_in_if.sink     in_i,
  vlmr_out_if.source  out_o
);

  localparam int unsigned RING_WORDS = RING_BYTES / 4;
  localparam int unsigned PW         = $clog2(RING_WORDS);
  localparam int unsigned DW         = (PW + 3 > 10) ? PW + 3 : 10;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_COPY  = 5'b00100,
    S_FHDR  = 5'b01000,
    S_FETCH = 5'b10000
  } state_e;

  state_e         state_q, state_d;
  logic [PW-1:0]  wp_q, wp_d;
  logic [PW-1:0]  rp_q, rp_d;
  logic [STAGE_IW-1:0] idx_q, idx_d;
  logic [6:0]     words_q, words_d;
  logic [8:0]     mbytes_q, mbytes_d;
  logic           empty_q, empty_d;

  // ring memory, one write and one registered read port
  logic [31:0]    ring_mem [RING_WORDS];
  logic           ring_we, ring_re;
  logic [PW-1:0]  ring_waddr, ring_raddr;
  logic [31:0]    ring_wdata, ring_rdata_q;

  // staging unit
  stage_req_t     stage_req;
  stage_rsp_t     stage_rsp;

  // output queue
  out_item_t      q_head_q, q_tail_q;
  logic [1:0]     q_cnt_q;
  out_item_t      res;
  logic           res_push;
  logic           can_push, pop;

  logic           in_fire;
  logic [PW:0]    used;
  logic [PW:0]    dist_words;
  logic [DW-1:0]  dist_bytes;
  logic [9:0]     padded;
  logic [6:0]     msg_words;
  logic [6:0]     full_words;
  logic           ring_is_empty;
  logic [PW-1:0]  wp_inc, rp_inc;
  logic [31:0]    hdr;
  logic           fetch_last;

  vlmr_stage u_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (stage_req),
    .rsp_o  (stage_rsp)
  );

  assign can_push = (q_cnt_q != 2'd2);
  assign pop      = (q_cnt_q != 2'd0) && out_o.ready;
  // a new item only enters when the sequencer is free and a result slot exists
  assign in_i.ready = (state_q == S_IDLE) && can_push;
  assign in_fire    = in_i.valid && in_i.ready;

  // ring occupancy in words, free distance is the rest of the ring
  always_comb begin
    if (wp_q >= rp_q) begin
      used = {1'b0, wp_q} - {1'b0, rp_q};
    end else begin
      used = {1'b0, wp_q} + (PW+1)'(RING_WORDS) - {1'b0, rp_q};
    end
    dist_words    = (PW+1)'(RING_WORDS) - used;
    dist_bytes    = DW'({dist_words, 2'b00});
    ring_is_empty = (used == '0);
    wp_inc        = (wp_q == PW'(RING_WORDS - 1)) ? '0 : wp_q + 1'b1;
    rp_inc        = (rp_q == PW'(RING_WORDS - 1)) ? '0 : rp_q + 1'b1;
  end

  // size of the staged message: in bytes with the header, rounded to whole words, and in payload words
  always_comb begin
    padded     = (10'(stage_rsp.staged_bytes) + 10'(HEADER_BYTES + 3)) & ~10'd3;
    msg_words  = 7'((stage_rsp.staged_bytes + 9'd3) >> 2);
    full_words = 7'(stage_rsp.staged_bytes >> 2);
  end

  assign hdr        = ring_rdata_q;
  assign fetch_last = ({1'b0, idx_q} == words_q - 7'd1);

  // sequencer
  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    idx_d    = idx_q;
    words_d  = words_q;
    mbytes_d = mbytes_q;
    empty_d  = empty_q;

    res_push = 1'b0;
    res      = '0;

    stage_req        = '0;
    stage_req.data   = in_i.data_word;
    stage_req.count  = in_i.byte_count;

    ring_we    = 1'b0;
    ring_waddr = wp_q;
    ring_wdata = '0;
    ring_re    = 1'b0;
    ring_raddr = rp_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.opcode == OP_APPEND) begin
            stage_req.push = 1'b1;
            if (in_i.last) begin
              state_d = S_CHECK;
            end else begin
              res_push       = 1'b1;
              res.status     = ST_ACCEPTED;
              res.ring_empty = ring_is_empty;
            end
          end else if (ring_is_empty) begin
            res_push       = 1'b1;
            res.status     = ST_FETCH_EMPTY;
            res.ring_empty = 1'b1;
          end else begin
            // header read, data back next cycle
            ring_re = 1'b1;
            state_d = S_FHDR;
          end
        end
      end

      S_CHECK: begin
        if (can_push) begin
          res_push       = 1'b1;
          res.ring_empty = ring_is_empty;
          if (dist_bytes < DW'(MAX_BATCH_BYTES)) begin
            res.status      = ST_NO_ROOM;
            stage_req.clear = 1'b1;
            state_d         = S_IDLE;
          end else if (padded > 10'(MAX_BATCH_BYTES)) begin
            res.status      = ST_TOO_LONG;
            stage_req.clear = 1'b1;
            state_d         = S_IDLE;
          end else if (DW'(padded) >= dist_bytes) begin
            // exact fill would make a full ring look empty
            res.status      = ST_NO_ROOM;
            stage_req.clear = 1'b1;
            state_d         = S_IDLE;
          end else begin
            res.status     = ST_ACCEPTED;
            res.ring_empty = 1'b0;
            ring_we        = 1'b1;
            ring_wdata     = {22'd0, padded};
            wp_d           = wp_inc;
            if (msg_words == 7'd0) begin
              stage_req.clear = 1'b1;
              state_d         = S_IDLE;
            end else begin
              stage_req.rd_en  = 1'b1;
              stage_req.rd_idx = '0;
              idx_d            = '0;
              state_d          = S_COPY;
            end
          end
        end
      end

      S_COPY: begin
        // trailing partial word comes from the packer, already zero-padded
        ring_we    = 1'b1;
        ring_wdata = ({1'b0, idx_q} == full_words) ? stage_rsp.partial_word
                                                   : stage_rsp.rd_data;
        wp_d       = wp_inc;
        if ({1'b0, idx_q} == msg_words - 7'd1) begin
          stage_req.clear = 1'b1;
          state_d         = S_IDLE;
        end else begin
          stage_req.rd_en  = 1'b1;
          stage_req.rd_idx = idx_q + 1'b1;
          idx_d            = idx_q + 1'b1;
        end
      end

      S_FHDR: begin
        if (hdr == 32'd0) begin
          res_push       = 1'b1;
          res.status     = ST_FETCH_EMPTY;
          res.ring_empty = ring_is_empty;
          state_d        = S_IDLE;
        end else begin
          if (hdr[31:8] != 24'd0) begin
            words_d = 7'd64;
          end else if (hdr[7:2] == 6'd0) begin
            words_d = 7'd1;
          end else begin
            words_d = {1'b0, hdr[7:2]};
          end
          if ((hdr[31:9] != 23'd0) || (hdr[8] && (hdr[7:0] != 8'd0))) begin
            mbytes_d = 9'd256;
          end else begin
            mbytes_d = hdr[8:0];
          end
          // ring drains to empty when this message is all that is held
          empty_d = (DW'(words_d) == DW'(used));
          idx_d   = '0;
          state_d = S_FETCH;
        end
      end

      S_FETCH: begin
        // read data holds while the queue is full
        if (can_push) begin
          res_push          = 1'b1;
          res.status        = ST_FETCH_WORD;
          res.out_word      = ring_rdata_q;
          res.message_bytes = mbytes_q;
          res.out_last      = fetch_last;
          res.ring_empty    = empty_q;
          ring_we           = 1'b1;
          ring_waddr        = rp_q;
          ring_wdata        = '0;
          rp_d              = rp_inc;
          if (fetch_last) begin
            state_d = S_IDLE;
          end else begin
            ring_re    = 1'b1;
            ring_raddr = rp_inc;
            idx_d      = idx_q + 1'b1;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wp_q     <= '0;
      rp_q     <= '0;
      idx_q    <= '0;
      words_q  <= '0;
      mbytes_q <= '0;
      empty_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      idx_q    <= idx_d;
      words_q  <= words_d;
      mbytes_q <= mbytes_d;
      empty_q  <= empty_d;
    end
  end

  // ring storage
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    if (ring_re) begin
      ring_rdata_q <= ring_mem[ring_raddr];
    end
  end

  // two-entry output queue, head drives the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= '0;
    end else begin
      q_cnt_q <= q_cnt_q + {1'b0, res_push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (res_push) begin
        if (q_cnt_q == 2'd1) begin
          q_head_q <= res;
        end else begin
          q_head_q <= q_tail_q;
          q_tail_q <= res;
        end
      end else begin
        q_head_q <= q_tail_q;
      end
    end else if (res_push) begin
      if (q_cnt_q == 2'd0) begin
        q_head_q <= res;
      end else begin
        q_tail_q <= res;
      end
    end
  end

  assign out_o.valid         = (q_cnt_q != 2'd0);
  assign out_o.status        = q_head_q.status;
  assign out_o.out_word      = q_head_q.out_word;
  assign out_o.message_bytes = q_head_q.message_bytes;
  assign out_o.out_last      = q_head_q.out_last;
  assign out_o.ring_empty    = q_head_q.ring_empty;

  // checks

  // no result is ever dropped into a full queue
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (q_cnt_q != 2'd2))
    else $error("result pushed into full output queue");

  // copy never runs past the staged message
  a_copy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY) |-> ({1'b0, idx_q} < msg_words))
    else $error("copy index beyond staged words");

  // a committed message never fills the ring completely
  a_copy_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY) |-> (wp_q != rp_q))
    else $error("write pointer caught up with read pointer during copy");

  // staging is empty once a commit finishes
  a_stage_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (($past(state_q) == S_COPY) && (state_q == S_IDLE)) |->
      (stage_rsp.staged_bytes == 9'd0))
    else $error("staging not cleared after commit");

  // a fetch leaves the write side alone
  a_fetch_wp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |=> $stable(wp_q))
    else $error("write pointer moved during fetch");

endmodule
